/* rtl/a5kc_pkg.sv */
// a5kc_pkg: shared types and constants for the a5 keystream byte cipher
// no dependencies; imported by a5kc_keygen and a5_keystream_byte_cipher_top
`default_nettype none

package a5kc_pkg;

    // register lengths
    localparam int LEN_ONE   = 19;
    localparam int LEN_TWO   = 22;
    localparam int LEN_THREE = 23;

    // clocking bit positions
    localparam int CLK_ONE   = 10;
    localparam int CLK_TWO   = 11;
    localparam int CLK_THREE = 12;

    // keystream bits made per data word (1 to 8)
    localparam int BITS_PER_ITEM = 8;
    localparam int BYTE_W        = 8;

    // configuration port
    localparam int CFG_DATA_W  = LEN_THREE;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEED_ONE   = 2'd0,
        CFG_SEED_TWO   = 2'd1,
        CFG_SEED_THREE = 2'd2
    } cfg_index_t;

    // function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_CRYPT = 1'b1;

    typedef struct packed {
        logic [LEN_ONE-1:0]   one;
        logic [LEN_TWO-1:0]   two;
        logic [LEN_THREE-1:0] three;
    } lfsr_state_t;

endpackage

`default_nettype wire

/* rtl/a5kc_keygen.sv */
// a5kc_keygen: unrolled majority-clocked keystream for one data word
// depends on a5kc_pkg
`default_nettype none

module a5kc_keygen
    import a5kc_pkg::*;
(
    input  wire lfsr_state_t       state_cur,
    output lfsr_state_t            state_new,
    output logic [BYTE_W-1:0]      key
);

    always_comb
    begin
        lfsr_state_t s;
        logic c1;
        logic c2;
        logic c3;
        logic maj;
        logic fb1;
        logic fb2;
        logic fb3;
        s   = state_cur;
        key = '0;
        for (int i = 0; i < BITS_PER_ITEM; i++)
        begin
            key[BYTE_W-1-i] = s.one[0] ^ s.two[0] ^ s.three[0];
            c1  = s.one[CLK_ONE];
            c2  = s.two[CLK_TWO];
            c3  = s.three[CLK_THREE];
            maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
            fb1 = s.one[0] ^ s.one[1] ^ s.one[2] ^ s.one[5];
            fb2 = s.two[0] ^ s.two[1];
            fb3 = s.three[0] ^ s.three[1] ^ s.three[2] ^ s.three[15];
            if (c1 == maj)
            begin
                s.one = {fb1, s.one[LEN_ONE-1:1]};
            end
            if (c2 == maj)
            begin
                s.two = {fb2, s.two[LEN_TWO-1:1]};
            end
            if (c3 == maj)
            begin
                s.three = {fb3, s.three[LEN_THREE-1:1]};
            end
        end
        state_new = s;
    end

endmodule

`default_nettype wire

/* rtl/a5_keystream_byte_cipher_top.sv */
// a5_keystream_byte_cipher_top: a word passes from the input register to the result register
// at one word per cycle while out_stall is low; the eight unrolled keystream steps in
// a5kc_keygen sit between the input register and the result register
// the input register takes a new word while a finished result waits, if it is empty
// rst_n (async, active low) clears seeds, shift registers and valid flags
// depends on a5kc_pkg and a5kc_keygen
`default_nettype none

module a5_keystream_byte_cipher_top
    import a5kc_pkg::*;
(
    input  wire                    clk,
    input  wire                    rst_n,
    // input channel
    input  wire                    in_valid,
    output logic                   in_stall,
    input  wire                    func,
    input  wire [BYTE_W-1:0]       data_in,
    // output channel
    output logic                   out_valid,
    input  wire                    out_stall,
    output logic [BYTE_W-1:0]      data_out,
    output logic [BYTE_W-1:0]      key_byte,
    // configuration write port
    input  wire                    cfg_we,
    input  wire [CFG_INDEX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data
);

    // seed registers
    logic [LEN_ONE-1:0]   seed_one_reg;
    logic [LEN_TWO-1:0]   seed_two_reg;
    logic [LEN_THREE-1:0] seed_three_reg;

    // input stage
    logic              s1_valid_reg;
    logic              s1_func_reg;
    logic [BYTE_W-1:0] s1_data_reg;

    // cipher state
    lfsr_state_t state_reg;
    lfsr_state_t state_next;
    lfsr_state_t state_stepped;
    lfsr_state_t state_seed;

    // result stage
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic [BYTE_W-1:0] out_key_reg;
    logic [BYTE_W-1:0] out_data_next;
    logic [BYTE_W-1:0] out_key_next;

    logic [BYTE_W-1:0] key_word;
    logic              s1_advance;
    logic              in_accept;

    // seed writes, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_one_reg   <= '0;
            seed_two_reg   <= '0;
            seed_three_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEED_ONE:   seed_one_reg   <= cfg_data[LEN_ONE-1:0];
                CFG_SEED_TWO:   seed_two_reg   <= cfg_data[LEN_TWO-1:0];
                CFG_SEED_THREE: seed_three_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // keystream for the word held in the input stage
    a5kc_keygen u_keygen (
        .state_cur (state_reg),
        .state_new (state_stepped),
        .key       (key_word)
    );

    // the input stage moves on when the result slot is empty or being taken
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign state_seed = '{one: seed_one_reg, two: seed_two_reg, three: seed_three_reg};

    always_comb
    begin
        state_next    = state_reg;
        out_data_next = out_data_reg;
        out_key_next  = out_key_reg;
        if (s1_advance)
        begin
            if (s1_func_reg == FUNC_LOAD)
            begin
                // load: take the seeds, result is zero
                state_next    = state_seed;
                out_data_next = '0;
                out_key_next  = '0;
            end
            else
            begin
                state_next    = state_stepped;
                out_data_next = s1_data_reg ^ key_word;
                out_key_next  = key_word;
            end
        end
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg <= func;
            s1_data_reg <= data_in;
        end
        out_data_reg <= out_data_next;
        out_key_reg  <= out_key_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;
    assign key_byte  = out_key_reg;

`ifndef SYNTH
    // state only moves when a word passes into the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(state_reg))
        else $error("cipher state changed without a word moving on");

    // a load gives an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_func_reg == FUNC_LOAD) |=>
            (out_data_reg == '0) && (out_key_reg == '0))
        else $error("load result not zero");

    // a cipher word unmasks back to its input
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && (s1_func_reg == FUNC_CRYPT) |=>
            ((out_data_reg ^ out_key_reg) == $past(s1_data_reg)))
        else $error("data word and key word disagree");

    // back-pressure only when the input stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

/* bench/a5_keystream_byte_cipher_top_tb.sv */
// a5_keystream_byte_cipher_top_tb: self-checking bench for the a5 keystream byte cipher
// drives seed writes and load/crypt words, predicts data_out and key_byte per word
// depends on a5kc_pkg and a5_keystream_byte_cipher_top

module a5_keystream_byte_cipher_top_tb;
    import a5kc_pkg::*;

    // quiet cycles (nothing accepted on either side) before the run is abandoned
    localparam int QUIET_LIMIT   = 2000;
    // words per random block; every block starts with fresh seeds
    localparam int BLOCK_WORDS   = 105;
    localparam int BLOCKS        = 9;
    // cycles allowed after the last expected word
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOW_LIMIT    = 10;

    // expectation source for a directed row
    localparam logic TYPED = 1'b1;
    localparam logic PRED  = 1'b0;

    typedef enum logic {ROW_WORD, ROW_SEEDS} row_kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] key;
    } cipher_word_t;

    // one row of the directed table: either a word or a set of three seeds
    typedef struct packed {
        row_kind_t            kind;
        logic                 fn;
        logic [BYTE_W-1:0]    data;
        logic [LEN_ONE-1:0]   s1;
        logic [LEN_TWO-1:0]   s2;
        logic [LEN_THREE-1:0] s3;
        logic                 typed_exp;
        logic [BYTE_W-1:0]    exp_data;
        logic [BYTE_W-1:0]    exp_key;
    } stim_row_t;

    localparam int DIR_ROWS = 22;
    localparam stim_row_t DIRECTED [0:DIR_ROWS-1] = '{
        // all-zero registers straight after reset: keystream is zero
        '{ROW_WORD,  FUNC_CRYPT, 8'h00, 19'h0, 22'h0, 23'h0, TYPED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'hFF, 19'h0, 22'h0, 23'h0, TYPED, 8'hFF, 8'h00},
        // load ignores data and answers zero
        '{ROW_WORD,  FUNC_LOAD,  8'hA5, 19'h0, 22'h0, 23'h0, TYPED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h5A, 19'h0, 22'h0, 23'h0, TYPED, 8'h5A, 8'h00},
        // every seed bit set
        '{ROW_SEEDS, FUNC_LOAD,  8'h00, 19'h7FFFF, 22'h3FFFFF, 23'h7FFFFF, PRED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_LOAD,  8'hFF, 19'h0, 22'h0, 23'h0, TYPED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h00, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'hFF, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h80, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h01, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        // reload mid-stream restarts the keystream
        '{ROW_WORD,  FUNC_LOAD,  8'h00, 19'h0, 22'h0, 23'h0, TYPED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h55, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'hAA, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        // single bits at the output end and at the top index
        '{ROW_SEEDS, FUNC_LOAD,  8'h00, 19'h00001, 22'h000000, 23'h400000, PRED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_LOAD,  8'h00, 19'h0, 22'h0, 23'h0, TYPED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h00, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h00, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'hFF, 19'h0, 22'h0, 23'h0, PRED,  8'h00, 8'h00},
        // back to zero seeds: loaded registers stay zero
        '{ROW_SEEDS, FUNC_LOAD,  8'h00, 19'h0, 22'h0, 23'h0, PRED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_LOAD,  8'h7E, 19'h0, 22'h0, 23'h0, TYPED, 8'h00, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'hC3, 19'h0, 22'h0, 23'h0, TYPED, 8'hC3, 8'h00},
        '{ROW_WORD,  FUNC_CRYPT, 8'h3C, 19'h0, 22'h0, 23'h0, TYPED, 8'h3C, 8'h00}
    };

    // ports; every input known from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic                   func      = FUNC_LOAD;
    logic [BYTE_W-1:0]      data_in   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [BYTE_W-1:0]      data_out;
    logic [BYTE_W-1:0]      key_byte;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SEED_ONE;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // predictor copy of the seeds and the three shift registers
    logic [LEN_ONE-1:0]   fill_one   = '0;
    logic [LEN_TWO-1:0]   fill_two   = '0;
    logic [LEN_THREE-1:0] fill_three = '0;
    logic [LEN_ONE-1:0]   sr_one     = '0;
    logic [LEN_TWO-1:0]   sr_two     = '0;
    logic [LEN_THREE-1:0] sr_three   = '0;

    cipher_word_t pending_words [$];

    int tx_idle_pct  = 37;
    int rx_idle_pct  = 69;
    int mismatches   = 0;
    int quiet_cycles = 0;

    a5_keystream_byte_cipher_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .key_byte  (key_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // one keystream bit: xor of the output ends, then majority-clocked shifts
    function automatic logic keystream_bit();
        logic ks;
        logic c1;
        logic c2;
        logic c3;
        logic maj;
        ks  = sr_one[0] ^ sr_two[0] ^ sr_three[0];
        c1  = sr_one[CLK_ONE];
        c2  = sr_two[CLK_TWO];
        c3  = sr_three[CLK_THREE];
        maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
        if (c1 == maj)
            sr_one = {sr_one[0] ^ sr_one[1] ^ sr_one[2] ^ sr_one[5], sr_one[LEN_ONE-1:1]};
        if (c2 == maj)
            sr_two = {sr_two[0] ^ sr_two[1], sr_two[LEN_TWO-1:1]};
        if (c3 == maj)
            sr_three = {sr_three[0] ^ sr_three[1] ^ sr_three[2] ^ sr_three[15],
                        sr_three[LEN_THREE-1:1]};
        return ks;
    endfunction

    // expected result of one accepted word, advancing the predictor state
    function automatic cipher_word_t cipher_word(input logic fn, input logic [BYTE_W-1:0] d);
        cipher_word_t r;
        r = '0;
        if (fn == FUNC_LOAD)
        begin
            sr_one   = fill_one;
            sr_two   = fill_two;
            sr_three = fill_three;
        end
        else
        begin
            // first keystream bit lands in the msb; unused low bits stay zero
            for (int i = 0; i < BYTE_W; i++)
                if (i < BITS_PER_ITEM)
                    r.key[BYTE_W-1-i] = keystream_bit();
            r.data = d ^ r.key;
        end
        return r;
    endfunction

    // hand one word over; the expectation is queued at the accepting edge
    task automatic send_word(input logic fn, input logic [BYTE_W-1:0] d,
                             input logic use_typed, input cipher_word_t typed_word);
        cipher_word_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= fn;
        data_in  <= d;
        @(posedge clk);
        // payload held while stalled
        while (in_stall)
            @(posedge clk);
        r = cipher_word(fn, d);
        if (use_typed)
            r = typed_word;
        pending_words.insert(pending_words.size(), r);
    endtask

    // let every outstanding word come back so the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // three back-to-back register writes, only ever called while idle
    task automatic write_seeds(input logic [LEN_ONE-1:0] s1, input logic [LEN_TWO-1:0] s2,
                               input logic [LEN_THREE-1:0] s3);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEED_ONE;
        cfg_data  <= CFG_DATA_W'(s1);
        @(posedge clk);
        cfg_index <= CFG_SEED_TWO;
        cfg_data  <= CFG_DATA_W'(s2);
        @(posedge clk);
        cfg_index <= CFG_SEED_THREE;
        cfg_data  <= CFG_DATA_W'(s3);
        @(posedge clk);
        cfg_we <= 1'b0;
        fill_one   = s1;
        fill_two   = s2;
        fill_three = s3;
    endtask

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    // result checker: each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        cipher_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected word: data_out %02h key_byte %02h", data_out, key_byte);
            end
            else
            begin
                want = pending_words.pop_front();
                if (data_out !== want.data || key_byte !== want.key)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("mismatch: expected data_out %02h key_byte %02h, got %02h %02h",
                                 want.data, want.key, data_out, key_byte);
                end
            end
        end
    end

    // quiet-cycle counter for the watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("** a5_keystream_byte_cipher_top: FAILED **");
        $finish;
    end

    initial
    begin
        stim_row_t            row;
        logic [LEN_ONE-1:0]   s1;
        logic [LEN_TWO-1:0]   s2;
        logic [LEN_THREE-1:0] s3;
        logic                 fn;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, sender idling lightly and receiver heavily
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_SEEDS)
            begin
                drain();
                write_seeds(row.s1, row.s2, row.s3);
            end
            else
            begin
                send_word(row.fn, row.data, row.typed_exp, '{row.exp_data, row.exp_key});
            end
        end

        // random blocks: three idling regimes, three seed settings each
        for (int b = 0; b < BLOCKS; b++)
        begin
            case (b / 3)
                0:
                begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 69;
                end
                1:
                begin
                    tx_idle_pct = 69;
                    rx_idle_pct = 37;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            drain();
            s1 = LEN_ONE'($urandom);
            s2 = LEN_TWO'($urandom);
            s3 = LEN_THREE'($urandom);
            // now and then leave one register empty
            case ($urandom_range(7))
                0:       s1 = '0;
                1:       s2 = '0;
                2:       s3 = '0;
                default: ;
            endcase
            write_seeds(s1, s2, s3);
            // mostly a load first, otherwise carry on from the old keystream
            if ($urandom_range(3) != 0)
                send_word(FUNC_LOAD, BYTE_W'($urandom), PRED, '0);
            for (int n = 0; n < BLOCK_WORDS; n++)
            begin
                fn = ($urandom_range(15) == 0) ? FUNC_LOAD : FUNC_CRYPT;
                send_word(fn, BYTE_W'($urandom), PRED, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("** a5_keystream_byte_cipher_top: PASSED **");
        else
            $display("** a5_keystream_byte_cipher_top: FAILED **");
        $finish;
    end

endmodule
